>>> rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/rrbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrbg_pkg;

  localparam int COORD_W      = 16;
  localparam int RX_W         = 12;
  localparam int RY_W         = 4;
  localparam int MAX_RADIUS_Y = 15;
  localparam int BAND_DEPTH   = 32;
  localparam int BAND_AW      = $clog2(BAND_DEPTH);
  localparam int CNT_W        = $clog2(BAND_DEPTH + 1);
  localparam int ACC_W        = 40;
  localparam int AA_W         = 2 * RX_W;
  localparam int BB_W         = 2 * RY_W;
  localparam int PROD_W       = AA_W + RY_W + 1;
  localparam int RUN_W        = RX_W + 1;

  typedef struct packed {
    logic [COORD_W-1:0] l;
    logic [COORD_W-1:0] t;
    logic [COORD_W-1:0] r;
    logic [COORD_W-1:0] b;
  } box_t;

  typedef struct packed {
    box_t box;
    logic box_valid;
    logic status;
    logic last;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL1,
    ST_MUL2,
    ST_INIT,
    ST_LOOP1,
    ST_ADJ1,
    ST_ADJ2,
    ST_ADJ3,
    ST_LOOP2,
    ST_PICK,
    ST_RD,
    ST_EM
  } st_t;

  typedef enum logic [2:0] {
    PH_ONE,
    PH_TOP,
    PH_MID,
    PH_SIDE_L,
    PH_SIDE_R,
    PH_BOT,
    PH_LOW
  } phase_t;

  // Signed halving that truncates toward zero.
  function automatic logic signed [ACC_W-1:0] tdiv2(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v + {{(ACC_W-1){1'b0}}, v[ACC_W-1]};
    return s >>> 1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rrbg_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbg_out_reg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire rrbg_pkg::res_t              load_data,
  output logic                             free,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_left,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_top,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_right,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_bottom,
  output logic                             out_box_valid,
  output logic                             out_status,
  output logic                             out_last
);
  import rrbg_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid      = valid_r;
  assign out_box_left   = data_r.box.l;
  assign out_box_top    = data_r.box.t;
  assign out_box_right  = data_r.box.r;
  assign out_box_bottom = data_r.box.b;
  assign out_box_valid  = data_r.box_valid;
  assign out_status     = data_r.status;
  assign out_last       = data_r.last;

endmodule

`default_nettype wire

>>> rtl/rounded_rect_band_generator.sv
// Channel  | Dir | Handshake             | Payload
// in_      | in  | in_valid / in_ready   | rect edges, radius_x, radius_y, filled
// out_     | out | out_valid / out_ready | box edges, box_valid, status, last
//
// One shape at a time: setup states SETUP, MUL1, MUL2 and INIT, then one corner pixel
// step per cycle (held while the first of two outline segments is written ahead),
// ADJ1 to ADJ3 for the octant switch, PICK for the emit pick, then RD and EM per box.
// Empty or small-radius shapes go from ST_SETUP through ST_RD to emit.
// rst_n is synchronous; band memories hold no reset and need no clearing.
// A full, stalled output holds the emit; in_ready rises once the last box is loaded.
`timescale 1ns / 1ps
`default_nettype none

module rounded_rect_band_generator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [rrbg_pkg::COORD_W-1:0] in_rect_left,
  input  wire logic signed [rrbg_pkg::COORD_W-1:0] in_rect_top,
  input  wire logic signed [rrbg_pkg::COORD_W-1:0] in_rect_right,
  input  wire logic signed [rrbg_pkg::COORD_W-1:0] in_rect_bottom,
  input  wire logic [rrbg_pkg::RX_W-1:0]      in_radius_x,
  input  wire logic [rrbg_pkg::RY_W-1:0]      in_radius_y,
  input  wire logic                           in_filled,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_left,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_top,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_right,
  output logic signed [rrbg_pkg::COORD_W-1:0] out_box_bottom,
  output logic                                out_box_valid,
  output logic                                out_status,
  output logic                                out_last
);
  import rrbg_pkg::*;

  st_t st_r, st_nxt;

  // captured transaction
  logic [COORD_W-1:0] xl_r, yt_r, xr_r, yb_r;
  logic [RX_W-1:0]    rx_r;
  logic [RY_W-1:0]    ry_r;
  logic               fl_r;

  logic [COORD_W:0]   h_r, h_nxt;
  logic [RX_W-1:0]    hx_r, hx_nxt;
  logic [RY_W-1:0]    hy_r, hy_nxt;
  logic [AA_W-1:0]    aa_r, aa_nxt;
  logic [BB_W-1:0]    bb_r, bb_nxt;
  logic [PROD_W-1:0]  p_r, p_nxt;

  logic signed [ACC_W-1:0] e_r, e_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [ACC_W-1:0] aa2_r, aa2_nxt, bb2_r, bb2_nxt, bb3_r, bb3_nxt;
  logic signed [ACC_W-1:0] k_r, k_nxt, sxb_r, sxb_nxt, t_r, t_nxt;

  logic [COORD_W-1:0] el_r, el_nxt, er_r, er_nxt, cy_r, cy_nxt, cy2_r, cy2_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [CNT_W-1:0]   nt_r, nt_nxt, idx_r, idx_nxt;
  logic               pre_r, pre_nxt;
  box_t               w0_r, w0_nxt, w1_r, w1_nxt, lw0_r, lw0_nxt, lw1_r, lw1_nxt;
  box_t               one_r, one_nxt;
  logic               one_valid_r, one_valid_nxt, one_status_r, one_status_nxt;
  phase_t             ph_r, ph_nxt;

  // band memories: top half and mirrored bottom half (outline)
  box_t               band_mem [BAND_DEPTH];
  box_t               low_mem  [BAND_DEPTH];
  box_t               rd_r, lrd_r;
  logic               wr_en;
  logic [BAND_AW-1:0] wr_addr;
  box_t               wr_data, lwr_data;

  // output stage
  logic               out_free, emit;
  res_t               res;

  // helpers
  logic [COORD_W:0]   w_full, h_full;
  logic [COORD_W-1:0] w_half;
  logic [COORD_W-1:0] h_half;
  logic [RY_W-1:0]    ry_sat;
  logic               bad_rect;
  logic               in_fire;
  logic               lp1_go, lp2_go;
  logic               cond1, cond2;
  logic               do_single, do_double, do_modify, in_pre;
  logic [COORD_W-1:0] rw;
  box_t               sb, sl, d0, d1, dl0, dl1;
  logic [CNT_W-1:0]   nt_m1, nt_m2;
  logic               nt_ge2;
  box_t               ent, lent;
  logic [COORD_W:0]   diff;
  logic [COORD_W+1:0] rim;
  logic               has_mid;
  logic [COORD_W-1:0] mid, bh;
  logic               em_done;

  assign in_fire = in_valid && in_ready;

  // ---------------- next state ----------------
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (in_fire) st_nxt = ST_SETUP;
      ST_SETUP: begin
        if (bad_rect || hx_nxt == '0 || hy_nxt == '0) begin
          st_nxt = ST_RD;
        end else begin
          st_nxt = ST_MUL1;
        end
      end
      ST_MUL1:  st_nxt = ST_MUL2;
      ST_MUL2:  st_nxt = ST_INIT;
      ST_INIT:  st_nxt = ST_LOOP1;
      ST_LOOP1: if (!lp1_go) st_nxt = ST_ADJ1;
      ST_ADJ1:  st_nxt = ST_ADJ2;
      ST_ADJ2:  st_nxt = ST_ADJ3;
      ST_ADJ3:  st_nxt = ST_LOOP2;
      ST_LOOP2: if (!lp2_go) st_nxt = ST_PICK;
      ST_PICK:  st_nxt = ST_RD;
      ST_RD:    st_nxt = ST_EM;
      ST_EM: begin
        if (emit) begin
          st_nxt = em_done ? ST_IDLE : ST_RD;
        end
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // ---------------- handshake outputs ----------------
  always_comb begin
    in_ready = 1'b0;
    emit     = 1'b0;
    case (st_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EM:   emit     = out_free;
      default: begin
        in_ready = 1'b0;
        emit     = 1'b0;
      end
    endcase
  end

  // ---------------- setup arithmetic ----------------
  assign w_full   = {xr_r[COORD_W-1], xr_r} - {xl_r[COORD_W-1], xl_r};
  assign h_full   = {yb_r[COORD_W-1], yb_r} - {yt_r[COORD_W-1], yt_r};
  assign w_half   = w_full[COORD_W:1];
  assign h_half   = h_full[COORD_W:1];
  assign ry_sat   = (ry_r > RY_W'(MAX_RADIUS_Y)) ? RY_W'(MAX_RADIUS_Y) : ry_r;
  assign bad_rect = ($signed(xl_r) >= $signed(xr_r)) || ($signed(yt_r) >= $signed(yb_r));

  // ---------------- step decode ----------------
  assign lp1_go = sx_r < sy_r;
  assign lp2_go = sy_r > 0;
  assign cond1  = e_r > 0;
  assign cond2  = e_r < 0;
  assign nt_m1  = nt_r - CNT_W'(1);
  assign nt_m2  = nt_r - CNT_W'(2);
  assign nt_ge2 = nt_r >= CNT_W'(2);

  always_comb begin
    do_single = 1'b0;
    do_double = 1'b0;
    do_modify = 1'b0;
    if (st_r == ST_LOOP1 && lp1_go && cond1) begin
      if (fl_r || nt_r == '0) begin
        do_single = 1'b1;
      end else begin
        do_double = 1'b1;
      end
    end else if (st_r == ST_LOOP2 && lp2_go) begin
      if (fl_r) begin
        if (nt_r != '0 && w1_r.l == el_r) begin
          do_modify = 1'b1;
        end else begin
          do_single = 1'b1;
        end
      end else if (nt_r == '0) begin
        do_single = 1'b1;
      end else if (w1_r.r == er_r) begin
        do_modify = 1'b1;
      end else begin
        do_double = 1'b1;
      end
    end
  end

  // a double push evicts two window entries; the first goes out in the cycle before the second
  assign in_pre = do_double && !pre_r;

  assign rw = (st_r == ST_LOOP1) ? COORD_W'(run_r) : COORD_W'(1);

  always_comb begin
    sb.l  = el_r;      sb.t  = cy_r;             sb.r  = er_r;      sb.b  = cy_r + 1'b1;
    sl.l  = el_r;      sl.t  = cy2_r - 1'b1;     sl.r  = er_r;      sl.b  = cy2_r;
    d0.l  = el_r;      d0.t  = cy_r;             d0.r  = el_r + rw; d0.b  = cy_r + 1'b1;
    d1.l  = er_r - rw; d1.t  = cy_r;             d1.r  = er_r;      d1.b  = cy_r + 1'b1;
    dl0.l = er_r - rw; dl0.t = cy2_r - 1'b1;     dl0.r = er_r;      dl0.b = cy2_r;
    dl1.l = el_r;      dl1.t = cy2_r - 1'b1;     dl1.r = el_r + rw; dl1.b = cy2_r;
  end

  // memory write port (shared address for both memories)
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = nt_m2[BAND_AW-1:0];
    wr_data  = w0_r;
    lwr_data = lw0_r;
    if (in_pre || do_single) begin
      wr_en = nt_ge2;
    end else if (do_double) begin
      wr_en    = 1'b1;
      wr_addr  = nt_m1[BAND_AW-1:0];
      wr_data  = w1_r;
      lwr_data = lw1_r;
    end
  end

  // ---------------- emit decode ----------------
  always_comb begin
    if (idx_r == nt_m1) begin
      ent  = w1_r;
      lent = lw1_r;
    end else if (idx_r == nt_m2) begin
      ent  = w0_r;
      lent = lw0_r;
    end else begin
      ent  = rd_r;
      lent = lrd_r;
    end
  end

  assign diff    = {cy_r[COORD_W-1], cy_r} - {yt_r[COORD_W-1], yt_r};
  assign rim     = {diff, 1'b0};
  assign has_mid = rim < {1'b0, h_r};
  assign mid     = h_r[COORD_W-1:0] - rim[COORD_W-1:0];
  assign bh      = ent.b - ent.t;

  // ---------------- datapath ----------------
  always_comb begin
    h_nxt = h_r; hx_nxt = hx_r; hy_nxt = hy_r;
    aa_nxt = aa_r; bb_nxt = bb_r; p_nxt = p_r;
    e_nxt = e_r; sx_nxt = sx_r; sy_nxt = sy_r;
    aa2_nxt = aa2_r; bb2_nxt = bb2_r; bb3_nxt = bb3_r;
    k_nxt = k_r; sxb_nxt = sxb_r; t_nxt = t_r;
    el_nxt = el_r; er_nxt = er_r; cy_nxt = cy_r; cy2_nxt = cy2_r;
    run_nxt = run_r; nt_nxt = nt_r; idx_nxt = idx_r; pre_nxt = pre_r;
    w0_nxt = w0_r; w1_nxt = w1_r; lw0_nxt = lw0_r; lw1_nxt = lw1_r;
    one_nxt = one_r; one_valid_nxt = one_valid_r; one_status_nxt = one_status_r;
    ph_nxt = ph_r;
    res.box = one_r; res.box_valid = 1'b1; res.status = 1'b0; res.last = 1'b0;
    em_done = 1'b0;

    case (st_r)
      ST_SETUP: begin
        h_nxt  = h_full;
        hx_nxt = ({4'd0, rx_r} < w_half) ? rx_r : w_half[RX_W-1:0];
        hy_nxt = ({12'd0, ry_sat} < h_half) ? ry_sat : h_half[RY_W-1:0];
        ph_nxt = PH_ONE;
        if (bad_rect) begin
          one_nxt        = '0;
          one_valid_nxt  = 1'b0;
          one_status_nxt = 1'b1;
        end else begin
          one_nxt.l      = xl_r;
          one_nxt.t      = yt_r;
          one_nxt.r      = xr_r;
          one_nxt.b      = yb_r;
          one_valid_nxt  = 1'b1;
          one_status_nxt = 1'b0;
        end
      end
      ST_MUL1: begin
        aa_nxt = hx_r * hx_r;
        bb_nxt = hy_r * hy_r;
      end
      ST_MUL2: begin
        p_nxt = aa_r * {hy_r, 1'b0};
      end
      ST_INIT: begin
        sy_nxt  = ACC_W'(p_r);
        sx_nxt  = '0;
        e_nxt   = ACC_W'(bb_r) - ACC_W'(p_r >> 1) + ACC_W'(aa_r >> 2);
        aa2_nxt = ACC_W'({aa_r, 1'b0});
        bb2_nxt = ACC_W'({bb_r, 1'b0});
        bb3_nxt = ACC_W'(bb_r) + ACC_W'({bb_r, 1'b0});
        el_nxt  = xl_r + COORD_W'(hx_r);
        er_nxt  = xr_r - COORD_W'(hx_r);
        cy_nxt  = yt_r;
        cy2_nxt = yb_r;
        nt_nxt  = '0;
        run_nxt = '0;
        pre_nxt = 1'b0;
      end
      ST_LOOP1, ST_LOOP2: begin
        if (in_pre) begin
          pre_nxt = 1'b1;
        end else if ((st_r == ST_LOOP1 && lp1_go) || (st_r == ST_LOOP2 && lp2_go)) begin
          pre_nxt = 1'b0;
          if (do_single) begin
            w0_nxt  = w1_r;
            w1_nxt  = sb;
            lw0_nxt = lw1_r;
            lw1_nxt = sl;
            nt_nxt  = nt_r + 1'b1;
          end else if (do_double) begin
            w0_nxt  = d0;
            w1_nxt  = d1;
            lw0_nxt = dl0;
            lw1_nxt = dl1;
            nt_nxt  = nt_r + CNT_W'(2);
          end else if (do_modify) begin
            w1_nxt.b = cy_r + 1'b1;
            if (!fl_r) begin
              lw1_nxt.t = lw1_r.t - 1'b1;
              if (nt_ge2) begin
                w0_nxt.b  = cy_r + 1'b1;
                lw0_nxt.t = lw0_r.t - 1'b1;
              end
            end
          end
          if (st_r == ST_LOOP1) begin
            if (cond1) begin
              cy_nxt  = cy_r + 1'b1;
              cy2_nxt = cy2_r - 1'b1;
              sy_nxt  = sy_r - aa2_r;
              run_nxt = RUN_W'(1);
              e_nxt   = e_r + (aa2_r - sy_r) + bb3_r + sx_r;
            end else begin
              run_nxt = run_r + 1'b1;
              e_nxt   = e_r + bb3_r + sx_r;
            end
            el_nxt = el_r - 1'b1;
            er_nxt = er_r + 1'b1;
            sx_nxt = sx_r + bb2_r;
          end else begin
            cy_nxt  = cy_r + 1'b1;
            cy2_nxt = cy2_r - 1'b1;
            sy_nxt  = sy_r - aa2_r;
            k_nxt   = k_r + aa2_r;
            if (cond2) begin
              el_nxt  = el_r - 1'b1;
              er_nxt  = er_r + 1'b1;
              sxb_nxt = sxb_r + bb2_r;
              e_nxt   = e_r + sxb_r + k_r;
            end else begin
              e_nxt   = e_r + k_r;
            end
          end
        end
      end
      ST_ADJ1: begin
        t_nxt = tdiv2((ACC_W'(aa_r) - ACC_W'(bb_r)) + ((ACC_W'(aa_r) - ACC_W'(bb_r)) <<< 1));
      end
      ST_ADJ2: begin
        t_nxt = tdiv2(t_r - sx_r - sy_r);
      end
      ST_ADJ3: begin
        e_nxt   = e_r + t_r;
        k_nxt   = ACC_W'(aa_r) + aa2_r - sy_r;
        sxb_nxt = sx_r + bb2_r;
      end
      ST_PICK: begin
        idx_nxt = '0;
        if (nt_r == '0) begin
          ph_nxt         = PH_ONE;
          one_nxt        = '0;
          one_valid_nxt  = 1'b0;
          one_status_nxt = 1'b0;
        end else begin
          ph_nxt = PH_TOP;
        end
      end
      ST_EM: begin
        case (ph_r)
          PH_ONE: begin
            res.box       = one_r;
            res.box_valid = one_valid_r;
            res.status    = one_status_r;
            res.last      = 1'b1;
            em_done       = 1'b1;
          end
          PH_TOP: begin
            res.box = ent;
            if (emit) begin
              if (idx_r == nt_m1) begin
                if (fl_r) begin
                  ph_nxt = has_mid ? PH_MID : PH_BOT;
                end else begin
                  ph_nxt = ($signed(cy_r) < $signed(cy2_r)) ? PH_SIDE_L : PH_LOW;
                end
              end else begin
                idx_nxt = idx_r + 1'b1;
              end
            end
          end
          PH_MID: begin
            res.box.l = el_r;
            res.box.t = cy_r;
            res.box.r = er_r;
            res.box.b = cy_r + mid;
            if (emit) begin
              cy_nxt = cy_r + mid;
              ph_nxt = PH_BOT;
            end
          end
          PH_SIDE_L: begin
            res.box.l = el_r;
            res.box.t = cy_r;
            res.box.r = el_r + 1'b1;
            res.box.b = cy2_r;
            if (emit) ph_nxt = PH_SIDE_R;
          end
          PH_SIDE_R: begin
            res.box.l = er_r - 1'b1;
            res.box.t = cy_r;
            res.box.r = er_r;
            res.box.b = cy2_r;
            if (emit) ph_nxt = PH_LOW;
          end
          PH_BOT: begin
            res.box.l = ent.l;
            res.box.t = cy_r;
            res.box.r = ent.r;
            res.box.b = cy_r + bh;
            res.last  = (idx_r == '0);
            em_done   = (idx_r == '0);
            if (emit) begin
              cy_nxt  = cy_r + bh;
              idx_nxt = idx_r - 1'b1;
            end
          end
          PH_LOW: begin
            res.box  = lent;
            res.last = (idx_r == '0);
            em_done  = (idx_r == '0);
            if (emit) idx_nxt = idx_r - 1'b1;
          end
          default: begin
            res.box = one_r;
          end
        endcase
      end
      default: begin
        res.box = one_r;
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      pre_r <= 1'b0;
      nt_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      pre_r <= pre_nxt;
      nt_r  <= (st_r == ST_EM && emit && ph_r == PH_TOP && idx_r == nt_m1) ? nt_r : nt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      xl_r <= in_rect_left;
      yt_r <= in_rect_top;
      xr_r <= in_rect_right;
      yb_r <= in_rect_bottom;
      rx_r <= in_radius_x;
      ry_r <= in_radius_y;
      fl_r <= in_filled;
    end
    h_r <= h_nxt; hx_r <= hx_nxt; hy_r <= hy_nxt;
    aa_r <= aa_nxt; bb_r <= bb_nxt; p_r <= p_nxt;
    e_r <= e_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    aa2_r <= aa2_nxt; bb2_r <= bb2_nxt; bb3_r <= bb3_nxt;
    k_r <= k_nxt; sxb_r <= sxb_nxt; t_r <= t_nxt;
    el_r <= el_nxt; er_r <= er_nxt; cy_r <= cy_nxt; cy2_r <= cy2_nxt;
    run_r <= run_nxt;
    w0_r <= w0_nxt; w1_r <= w1_nxt; lw0_r <= lw0_nxt; lw1_r <= lw1_nxt;
    one_r <= one_nxt; one_valid_r <= one_valid_nxt; one_status_r <= one_status_nxt;
    ph_r <= ph_nxt;
    // entering the bottom walk points at the last entry
    if (st_r == ST_EM && emit && ph_r == PH_TOP && idx_r == nt_m1) begin
      idx_r <= nt_m1;
    end else if (st_r == ST_EM && emit && ph_r == PH_MID) begin
      idx_r <= nt_m1;
    end else if (st_r == ST_EM && emit && ph_r == PH_SIDE_R) begin
      idx_r <= nt_m1;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      band_mem[wr_addr] <= wr_data;
      low_mem[wr_addr]  <= lwr_data;
    end
    rd_r  <= band_mem[idx_r[BAND_AW-1:0]];
    lrd_r <= low_mem[idx_r[BAND_AW-1:0]];
  end

  rrbg_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (emit),
    .load_data      (res),
    .free           (out_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_box_left   (out_box_left),
    .out_box_top    (out_box_top),
    .out_box_right  (out_box_right),
    .out_box_bottom (out_box_bottom),
    .out_box_valid  (out_box_valid),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

>>> rtl/rrbg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrbg_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic signed [rrbg_pkg::COORD_W-1:0] out_box_left,
  input wire logic signed [rrbg_pkg::COORD_W-1:0] out_box_bottom,
  input wire logic                           out_box_valid,
  input wire logic                           out_status,
  input wire logic                           out_last
);

  // a held result keeps its left, bottom and last fields
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_box_left) && $stable(out_box_bottom) && $stable(out_last))

  // an accepted shape keeps the input side closed on the next cycle
  `AST_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)

  // an invalid rectangle gives one empty closing result
  `AST_IMPLY(a_status_alone, clk, rst_n, out_valid && out_status, out_last && !out_box_valid)

  // an empty result always closes its shape
  `AST_IMPLY(a_empty_last, clk, rst_n, out_valid && !out_box_valid, out_last)

endmodule

bind rounded_rect_band_generator rrbg_checker u_rrbg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_box_left   (out_box_left),
  .out_box_bottom (out_box_bottom),
  .out_box_valid  (out_box_valid),
  .out_status     (out_status),
  .out_last       (out_last)
);

`default_nettype wire

>>> dv/tb_rounded_rect_band_generator.sv
`timescale 1ns / 1ps

module tb_rounded_rect_band_generator;
  import rrbg_pkg::*;

  typedef struct {
    logic signed [15:0] l, t, r, b;
    logic [11:0] rx;
    logic [3:0]  ry;
    logic        fl;
  } shape_t;

  typedef struct {
    logic signed [15:0] l, t, r, b;
    logic bv, st, lst;
  } box_res_t;

  typedef struct {
    longint l, t, r, b;
  } band_t;

  // directed row: shape plus optional typed-in single result
  typedef struct {
    shape_t   s;
    bit       typed;
    box_res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_rect_left = '0, in_rect_top = '0;
  logic signed [15:0] in_rect_right = '0, in_rect_bottom = '0;
  logic [11:0] in_radius_x = '0;
  logic [3:0]  in_radius_y = '0;
  logic in_filled = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_box_left, out_box_top, out_box_right, out_box_bottom;
  logic out_box_valid, out_status, out_last;

  box_res_t pending_boxes[$];
  int errors = 0;
  int shapes_sent = 0;
  int boxes_seen = 0;
  int filled_sent = 0;
  int outline_sent = 0;
  bit stim_done = 1'b0;

  rounded_rect_band_generator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rect_left(in_rect_left), .in_rect_top(in_rect_top),
    .in_rect_right(in_rect_right), .in_rect_bottom(in_rect_bottom),
    .in_radius_x(in_radius_x), .in_radius_y(in_radius_y), .in_filled(in_filled),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_box_left(out_box_left), .out_box_top(out_box_top),
    .out_box_right(out_box_right), .out_box_bottom(out_box_bottom),
    .out_box_valid(out_box_valid), .out_status(out_status), .out_last(out_last)
  );

  always #6 clk = ~clk;

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH box %0d %s: got %0d expected %0d", boxes_seen, what, got, want);
  endtask

  function automatic box_res_t mk_box(longint l, longint t, longint r, longint b,
                                      bit bv, bit st);
    box_res_t x;
    x.l = l[15:0]; x.t = t[15:0]; x.r = r[15:0]; x.b = b[15:0];
    x.bv = bv; x.st = st; x.lst = 1'b0;
    return x;
  endfunction

  // Midpoint-ellipse band expansion of one shape.
  function automatic void predict_bands(input shape_t s, ref box_res_t q[$]);
    longint xl, yt, xr, yb, rx, ry, w, h, ew, eh, aa, bb, aa2, bb2;
    longint e, sx, sy, el, er, cy, cy2, run, rim, bh;
    band_t top[$];
    band_t low[$];
    box_res_t res[$];
    band_t nb;
    xl = s.l; yt = s.t; xr = s.r; yb = s.b;
    rx = s.rx; ry = s.ry;
    if (ry > MAX_RADIUS_Y) ry = MAX_RADIUS_Y;
    if (xl >= xr || yt >= yb) begin
      res.push_back(mk_box(0, 0, 0, 0, 0, 1));
    end else begin
      w = xr - xl; h = yb - yt;
      ew = rx * 2; if (ew > w) ew = w;
      eh = ry * 2; if (eh > h) eh = h;
      if (ew < 2 || eh < 2) begin
        res.push_back(mk_box(xl, yt, xr, yb, 1, 0));
      end else begin
        ew -= ew & 1; eh -= eh & 1;
        aa = (ew / 2) * (ew / 2);
        bb = (eh / 2) * (eh / 2);
        e = bb - aa * eh / 2 + aa / 4;
        sx = 0; sy = aa * eh; aa2 = aa * 2; bb2 = bb * 2;
        el = xl + ew / 2; er = xr - ew / 2;
        cy = yt; cy2 = yb; run = 0;
        if (s.fl) begin
          while (sx < sy) begin
            if (e > 0) begin
              if (top.size() < BAND_DEPTH) begin
                nb = '{el, cy, er, cy + 1}; top.push_back(nb);
              end
              cy++; sy -= aa2; e -= sy;
            end
            el--; er++; sx += bb2; e += bb + sx;
          end
          e += (3 * (aa - bb) / 2 - (sx + sy)) / 2;
          while (sy > 0) begin
            if (top.size() > 0 && top[$].l == el) top[$].b = cy + 1;
            else if (top.size() < BAND_DEPTH) begin
              nb = '{el, cy, er, cy + 1}; top.push_back(nb);
            end
            cy++;
            if (e < 0) begin el--; er++; sx += bb2; e += sx; end
            sy -= aa2; e += aa - sy;
          end
          if (top.size() > 0) begin
            rim = (cy - yt) * 2;
            foreach (top[i]) res.push_back(mk_box(top[i].l, top[i].t, top[i].r, top[i].b, 1, 0));
            if (rim < h) begin
              res.push_back(mk_box(el, cy, er, cy + h - rim, 1, 0));
              cy += h - rim;
            end
            for (int i = top.size() - 1; i >= 0; i--) begin
              bh = top[i].b - top[i].t;
              res.push_back(mk_box(top[i].l, cy, top[i].r, cy + bh, 1, 0));
              cy += bh;
            end
          end
        end else begin
          while (sx < sy) begin
            if (e > 0) begin
              if (top.size() == 0) begin
                nb = '{el, cy, er, cy + 1}; top.push_back(nb);
                nb = '{el, cy2 - 1, er, cy2}; low.push_back(nb);
              end else begin
                nb = '{el, cy, el + run, cy + 1};
                if (top.size() < BAND_DEPTH) top.push_back(nb);
                nb = '{er - run, cy, er, cy + 1};
                if (top.size() < BAND_DEPTH) top.push_back(nb);
                nb = '{er - run, cy2 - 1, er, cy2};
                if (low.size() < BAND_DEPTH) low.push_back(nb);
                nb = '{el, cy2 - 1, el + run, cy2};
                if (low.size() < BAND_DEPTH) low.push_back(nb);
              end
              cy++; cy2--; sy -= aa2; e -= sy; run = 0;
            end
            el--; er++; run++; sx += bb2; e += bb + sx;
          end
          e += (3 * (aa - bb) / 2 - (sx + sy)) / 2;
          while (sy > 0) begin
            if (top.size() == 0) begin
              nb = '{el, cy, er, cy + 1}; top.push_back(nb);
              nb = '{el, cy2 - 1, er, cy2}; low.push_back(nb);
            end else if (top[$].r == er) begin
              top[$].b = cy + 1;
              if (low.size() > 0) low[$].t--;
              if (top.size() >= 2 && low.size() >= 2) begin
                top[top.size() - 2].b = cy + 1;
                low[low.size() - 2].t--;
              end
            end else begin
              nb = '{el, cy, el + 1, cy + 1};
              if (top.size() < BAND_DEPTH) top.push_back(nb);
              nb = '{er - 1, cy, er, cy + 1};
              if (top.size() < BAND_DEPTH) top.push_back(nb);
              nb = '{er - 1, cy2 - 1, er, cy2};
              if (low.size() < BAND_DEPTH) low.push_back(nb);
              nb = '{el, cy2 - 1, el + 1, cy2};
              if (low.size() < BAND_DEPTH) low.push_back(nb);
            end
            cy++; cy2--;
            if (e < 0) begin el--; er++; sx += bb2; e += sx; end
            sy -= aa2; e += aa - sy;
          end
          if (top.size() > 0) begin
            foreach (top[i]) res.push_back(mk_box(top[i].l, top[i].t, top[i].r, top[i].b, 1, 0));
            if (cy < cy2) begin
              res.push_back(mk_box(el, cy, el + 1, cy2, 1, 0));
              res.push_back(mk_box(er - 1, cy, er, cy2, 1, 0));
            end
            for (int i = low.size() - 1; i >= 0; i--)
              res.push_back(mk_box(low[i].l, low[i].t, low[i].r, low[i].b, 1, 0));
          end
        end
        if (res.size() == 0) res.push_back(mk_box(0, 0, 0, 0, 0, 0));
      end
    end
    while (res.size() > 64) void'(res.pop_back());
    res[$].lst = 1'b1;
    foreach (res[i]) q.push_back(res[i]);
  endfunction

  // drops valid only when a real gap follows
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // leaves valid high after the accepting edge; the caller or the next gap drops it
  task automatic send_shape(input shape_t s, input bit gaps);
    if (gaps) idle_gap();
    predict_bands(s, pending_boxes);
    in_valid <= 1'b1;
    in_rect_left <= s.l; in_rect_top <= s.t;
    in_rect_right <= s.r; in_rect_bottom <= s.b;
    in_radius_x <= s.rx; in_radius_y <= s.ry; in_filled <= s.fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shapes_sent++;
    if (s.fl) filled_sent++; else outline_sent++;
  endtask

  function automatic shape_t rand_shape();
    shape_t s;
    int w, h, mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // raw noise: any edges, often empty
      s.l = $urandom; s.t = $urandom; s.r = $urandom; s.b = $urandom;
      s.rx = $urandom; s.ry = $urandom;
    end else begin
      w = (mode == 1) ? $urandom_range(1, 4000) : $urandom_range(1, 60);
      h = $urandom_range(1, 40);
      s.l = $urandom_range(0, 65535) - 32768;
      if (s.l > 32767 - w) s.l = 32767 - w;
      s.t = $urandom_range(0, 65535) - 32768;
      if (s.t > 32767 - h) s.t = 32767 - h;
      s.r = s.l + w; s.b = s.t + h;
      s.rx = (mode == 1) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
      s.ry = $urandom_range(0, 15);
    end
    s.fl = $urandom_range(0, 1);
    return s;
  endfunction

  // result side: random stall, check each transaction against oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      boxes_seen++;
      if (pending_boxes.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        box_res_t w;
        w = pending_boxes.pop_front();
        if (out_box_left !== w.l) report("left", out_box_left, w.l);
        if (out_box_top !== w.t) report("top", out_box_top, w.t);
        if (out_box_right !== w.r) report("right", out_box_right, w.r);
        if (out_box_bottom !== w.b) report("bottom", out_box_bottom, w.b);
        if (out_box_valid !== w.bv) report("box_valid", out_box_valid, w.bv);
        if (out_status !== w.st) report("status", out_status, w.st);
        if (out_last !== w.lst) report("last", out_last, w.lst);
      end
    end
    if (!rst_n) out_ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : 1'b1;
    else if ($urandom_range(0, 30) == 0) out_ready <= 1'b0;
    else out_ready <= (boxes_seen % 200 < 60) ? 1'b1 : out_ready | ($urandom_range(0, 2) == 0);
  end

  initial begin
    #60_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    shape_t s;
    box_res_t chk[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty rectangles -> status invalid
    r.typed = 1; r.want = '{0, 0, 0, 0, 1'b0, 1'b1, 1'b1};
    r.s = '{16'sd10, 16'sd10, 16'sd10, 16'sd20, 12'd3, 4'd3, 1'b1}; rows.push_back(r);
    r.s = '{16'sd0, 16'sd5, 16'sd9, 16'sd4, 12'd3, 4'd3, 1'b0}; rows.push_back(r);
    r.s = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 12'hfff, 4'hf, 1'b1};
    rows.push_back(r);
    // small radius -> plain rectangle
    r.s = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 12'd0, 4'hf, 1'b1};
    r.want = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 1'b1};
    rows.push_back(r);
    r.s = '{16'sd0, 16'sd0, 16'sd50, 16'sd1, 12'hfff, 4'hf, 1'b0};
    r.want = '{16'sd0, 16'sd0, 16'sd50, 16'sd1, 1'b1, 1'b0, 1'b1};
    rows.push_back(r);
    r.s = '{16'sd3, 16'sd3, 16'sd8, 16'sd40, 12'd7, 4'd0, 1'b1};
    r.want = '{16'sd3, 16'sd3, 16'sd8, 16'sd40, 1'b1, 1'b0, 1'b1};
    rows.push_back(r);
    // predictor-checked: both modes, radius extremes, full-width bands
    r.typed = 0;
    r.s = '{16'sd0, 16'sd0, 16'sd40, 16'sd30, 12'd10, 4'd6, 1'b1}; rows.push_back(r);
    r.s = '{16'sd0, 16'sd0, 16'sd40, 16'sd30, 12'd10, 4'd6, 1'b0}; rows.push_back(r);
    r.s = '{16'sd0, 16'sd0, 16'sd2, 16'sd2, 12'd1, 4'd1, 1'b1}; rows.push_back(r);
    r.s = '{16'sd0, 16'sd0, 16'sd2, 16'sd2, 12'd1, 4'd1, 1'b0}; rows.push_back(r);
    r.s = '{-16'sd20, -16'sd20, 16'sd20, 16'sd20, 12'd1, 4'd15, 1'b0}; rows.push_back(r);
    r.s = '{-16'sd20, -16'sd20, 16'sd20, 16'sd20, 12'd15, 4'd1, 1'b0}; rows.push_back(r);
    r.s = '{16'sd100, 16'sd0, 16'sd4195, 16'sd31, 12'hfff, 4'hf, 1'b1}; rows.push_back(r);
    r.s = '{16'sd100, 16'sd0, 16'sd4195, 16'sd31, 12'hfff, 4'hf, 1'b0}; rows.push_back(r);
    r.s = '{16'sh7fc0, 16'sh7fc0, 16'sh7fff, 16'sh7fff, 12'd30, 4'd15, 1'b1};
    rows.push_back(r);
    r.s = '{16'sh8000, 16'sh8000, 16'sh8030, 16'sh8030, 12'd30, 4'd15, 1'b0};
    rows.push_back(r);
    r.s = '{16'sd0, 16'sd0, 16'sd7, 16'sd5, 12'd2, 4'd2, 1'b0}; rows.push_back(r);
    r.s = '{16'sd0, 16'sd0, 16'sd9, 16'sd3, 12'd9, 4'd9, 1'b1}; rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        chk.delete();
        predict_bands(rows[i].s, chk);
        if (chk.size() != 1 || chk[0] != rows[i].want) begin
          report("directed row typed result", i, 0);
        end
      end
      send_shape(rows[i].s, i % 3 == 0);
      // this shape's result cannot leave before its acceptance edge
      if (rows[i].typed) pending_boxes[$] = rows[i].want;
    end

    for (int n = 0; n < 122; n++) begin
      s = rand_shape();
      send_shape(s, n >= 30);
      // drain hold-off once mid-run
      if (n == 70) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_boxes.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d shapes (%0d filled, %0d outline), %0d boxes checked",
             shapes_sent, filled_sent, outline_sent, boxes_seen);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
